// File: hdl/sqn_freshness_array_check_assert.svh
// Assertion macros shared by the freshness check RTL.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef SQN_FRESHNESS_ARRAY_CHECK_ASSERT_SVH
`define SQN_FRESHNESS_ARRAY_CHECK_ASSERT_SVH

// Same-cycle implication.
`define SFAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sfac_pkg.sv
// Shared constants and types for the sequence number freshness check.
// No dependencies.
package sfac_pkg;

  localparam int SQN_BITS    = 48;
  localparam int IDX_BITS    = 5;
  localparam int NUM_ENTRIES = 1 << IDX_BITS;
  localparam int SEQ_BITS    = SQN_BITS - IDX_BITS;

  typedef logic [SQN_BITS-1:0] sqn_t;
  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [SEQ_BITS-1:0] seq_t;

  // Sequence value: the number without its index bits.
  function automatic seq_t seq_of(input sqn_t sqn);
    seq_of = sqn[SQN_BITS-1:IDX_BITS];
  endfunction

endpackage

// File: hdl/sfac_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old contents.
module sfac_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sqn_freshness_array_check.sv
// Sequence number freshness check against an array of accepted numbers.
// Input channel in_*: in_tdata = sqn_in[47:0]; bits 4..0 pick one of 32
// entries, bits 47..5 are the sequence value compared against that entry.
// Output channel out_*: out_tuser = fresh, out_tdata = sqn_out[47:0].
// A fresh number (sequence value strictly above the entry's) is stored and
// echoed with fresh = 1; the highest index follows it when it also beats the
// entry at the highest index. Otherwise fresh = 0 and the number stored at
// the highest index is returned.
// Path: the input transfer loads the input register and issues the RAM read,
// then the compare stage moves into the output register that drives
// out_tvalid. Throughput: one item per cycle while the receiver keeps taking
// results; the entry RAM has one registered read port and one write port,
// with forwarding for a write that lands on the cycle of the next read.
// Reset (rst_n low, synchronous) clears per-entry valid bits, the highest
// index and its cached value, so every entry reads as zero; no clearing pass.
// A stalled receiver holds the output register and the compare stage; input
// is taken while the compare stage is empty or moving.
module sqn_freshness_array_check
  import sfac_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SQN_BITS-1:0] in_tdata,   // [47:0] sqn_in
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SQN_BITS-1:0] out_tdata,  // [47:0] sqn_out
  output logic                out_tuser   // [0] fresh
);

`include "sqn_freshness_array_check_assert.svh"

  // Compare stage
  logic s1_v_r, s1_v_nxt;
  sqn_t s1_sqn_r, s1_sqn_nxt;
  // Last write, forwarded to a read issued at the same edge
  logic wr_v_r, wr_v_nxt;
  idx_t wr_addr_r, wr_addr_nxt;
  sqn_t wr_data_r, wr_data_nxt;
  // Entry state
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  idx_t max_index_r, max_index_nxt;
  sqn_t highest_r, highest_nxt;   // copy of the entry at max_index_r
  // Output register
  logic out_v_r, out_v_nxt;
  logic out_fresh_r, out_fresh_nxt;
  sqn_t out_sqn_r, out_sqn_nxt;

  logic in_xfer, s1_adv, fresh, beats_top, ram_we;
  idx_t s1_idx;
  sqn_t rd_data, entry;

  assign in_xfer = in_tvalid && in_tready;
  assign s1_adv  = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  sfac_ram #(
    .DATA_W (SQN_BITS),
    .DEPTH  (NUM_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_idx),
    .wr_data (s1_sqn_r),
    .rd_en   (in_xfer),
    .rd_addr (in_tdata[IDX_BITS-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_idx = s1_sqn_r[IDX_BITS-1:0];
    if (wr_v_r && (wr_addr_r == s1_idx)) begin
      entry = wr_data_r;
    end else if (valid_r[s1_idx]) begin
      entry = rd_data;
    end else begin
      entry = '0;
    end
    fresh     = seq_of(s1_sqn_r) > seq_of(entry);
    beats_top = seq_of(s1_sqn_r) > seq_of(highest_r);
    ram_we    = s1_adv && fresh;
  end

  always_comb begin
    s1_v_nxt      = s1_v_r;
    s1_sqn_nxt    = s1_sqn_r;
    wr_v_nxt      = wr_v_r;
    wr_addr_nxt   = wr_addr_r;
    wr_data_nxt   = wr_data_r;
    valid_nxt     = valid_r;
    max_index_nxt = max_index_r;
    highest_nxt   = highest_r;
    out_v_nxt     = out_v_r;
    out_fresh_nxt = out_fresh_r;
    out_sqn_nxt   = out_sqn_r;

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_v_nxt      = 1'b0;
      out_v_nxt     = 1'b1;
      out_fresh_nxt = fresh;
      out_sqn_nxt   = fresh ? s1_sqn_r : highest_r;
      wr_v_nxt      = fresh;
      wr_addr_nxt   = s1_idx;
      wr_data_nxt   = s1_sqn_r;
      if (fresh) begin
        valid_nxt[s1_idx] = 1'b1;
        // Overwriting the top slot, or beating it from another slot
        if (s1_idx == max_index_r) begin
          highest_nxt = s1_sqn_r;
        end else if (beats_top) begin
          highest_nxt   = s1_sqn_r;
          max_index_nxt = s1_idx;
        end
      end
    end
    if (in_xfer) begin
      s1_v_nxt   = 1'b1;
      s1_sqn_nxt = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      wr_v_r      <= 1'b0;
      valid_r     <= '0;
      max_index_r <= '0;
      highest_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      wr_v_r      <= wr_v_nxt;
      valid_r     <= valid_nxt;
      max_index_r <= max_index_nxt;
      highest_r   <= highest_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sqn_r    <= s1_sqn_nxt;
    wr_addr_r   <= wr_addr_nxt;
    wr_data_r   <= wr_data_nxt;
    out_fresh_r <= out_fresh_nxt;
    out_sqn_r   <= out_sqn_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sqn_r;
  assign out_tuser  = out_fresh_r;

  `SFAC_ASSERT_NEXT(a_fail_keeps_top, s1_adv && !fresh,
    max_index_r == $past(max_index_r) && highest_r == $past(highest_r),
    "failed check moved the highest index")
  `SFAC_ASSERT_NEXT(a_fresh_marks_valid, s1_adv && fresh,
    valid_r[$past(s1_idx)] && wr_v_r && out_tuser,
    "fresh transfer not recorded")
  `SFAC_ASSERT_NOW(a_unwritten_top_zero, !valid_r[max_index_r],
    highest_r == '0,
    "highest copy nonzero for an unwritten entry")
  `SFAC_ASSERT_NEXT(a_fail_returns_top, s1_adv && !fresh,
    out_tdata == $past(highest_r),
    "failed check did not return the highest entry")

endmodule
